@@ sv/cfir_pkg.sv @@
package cfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 40;
  localparam int TAPS_DEF   = 39;
  localparam int COEF_W_DEF = 18;
  localparam int COEF_COUNT = 39;
  localparam int COEF_MAX_W = 25;

  // Unique low-pass taps in Q1.17; tap k mirrors tap COEF_COUNT-1-k.
  localparam int HALF_TAPS [20] = '{
    -23, -142, -256, -307, -189, 177, 736, 1238, 1288, 543,
    -1028, -2957, -4294, -3902, -930, 4721, 12167, 19698, 25304, 27377
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       block_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Tap k rescaled from Q1.17 to Q1.(cw-1), rounding half up when narrowing.
  function automatic logic signed [COEF_MAX_W-1:0] coef_value(input int k, input int cw);
    int c;
    int r;
    c = 0;
    r = 0;
    if (k >= 0 && k < COEF_COUNT) begin
      c = (k <= 19) ? HALF_TAPS[k] : HALF_TAPS[COEF_COUNT - 1 - k];
      if (cw >= 18) begin
        r = c <<< (cw - 18);
      end else begin
        r = (c + (1 << (17 - cw))) >>> (18 - cw);
      end
    end
    return COEF_MAX_W'(r);
  endfunction

endpackage

@@ sv/complex_fir_lowpass_filter.sv @@
// Each result sums the new sample and n history samples, where n is the
// number of history samples in use (0 after block start, up to TAPS-1).
// A new item is taken only once the current result is in the output register;
// taps run one a cycle through one I/Q MAC pair off the single history read port.
// Reset clears the pointer, history count and handshake state; the history
// memory is not cleared, as entries are only read once written.
module complex_fir_lowpass_filter #(
  parameter int TAPS       = cfir_pkg::TAPS_DEF,
  parameter int COEF_WIDTH = cfir_pkg::COEF_W_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  cfir_pkg::in_item_t  sample,
  output logic                result_valid,
  input  logic                result_ready,
  output cfir_pkg::out_item_t result
);
  import cfir_pkg::*;

  localparam int DEPTH = TAPS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(TAPS);
  localparam int PW    = SAMPLE_W + COEF_WIDTH;
  localparam int YW    = ACC_W + 2 - COEF_WIDTH;
  localparam logic [ACC_W:0] HALF_LSB = (ACC_W + 1)'(1) << (COEF_WIDTH - 2);
  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint SAT_LO = -(64'sd1 <<< (SAMPLE_W - 1));

  state_t state, state_next;

  logic [KW-1:0] k, n, vc;
  logic [AW-1:0] ptr, rd_addr;
  logic signed [SAMPLE_W-1:0] x_i, x_q;

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [2*SAMPLE_W-1:0] rdata;

  logic                         s1_v, s1_x;
  logic signed [COEF_WIDTH-1:0] s1_c, coef_k;
  logic                         s2_v;
  logic signed [PW-1:0]         prod_i, prod_q;
  logic signed [ACC_W-1:0]      acc_i, acc_q;

  logic accept, issue, finish, out_free;
  logic signed [SAMPLE_W-1:0] op_i, op_q, y_i, y_q;
  logic signed [ACC_W:0]      sum_i, sum_q;

  function automatic logic signed [SAMPLE_W-1:0] saturate(input logic signed [YW-1:0] y);
    longint v;
    v = 64'(y);
    if (v > SAT_HI) begin
      v = SAT_HI;
    end else if (v < SAT_LO) begin
      v = SAT_LO;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  assign out_free = !result_valid || result_ready;
  assign accept   = sample_valid && sample_ready;
  assign coef_k   = COEF_WIDTH'(coef_value(int'(k), COEF_WIDTH));

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    issue        = 1'b0;
    finish       = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        issue = 1'b1;
        if (k == n) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the MAC pipeline to empty and the output register to free up
        if (!s1_v && !s2_v && out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: tap index, taps in use, pointer and history count
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= '0;
      n   <= '0;
      vc  <= '0;
      ptr <= '0;
    end else begin
      if (accept) begin
        k <= '0;
        n <= sample.block_start ? '0 : vc;
      end else if (issue && k != n) begin
        k <= k + KW'(1);
      end
      if (finish) begin
        vc  <= (n == KW'(DEPTH)) ? n : n + KW'(1);
        ptr <= (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_i     <= sample.sample_i;
      x_q     <= sample.sample_q;
      rd_addr <= (ptr == '0) ? AW'(DEPTH - 1) : ptr - AW'(1);
    end else if (issue && k != '0) begin
      rd_addr <= (rd_addr == '0) ? AW'(DEPTH - 1) : rd_addr - AW'(1);
    end
  end

  // History memory: one read port for the taps, one write port for the new sample
  always_ff @(posedge clk) begin
    if (finish) begin
      mem[ptr] <= {x_i, x_q};
    end
    if (issue && k != '0) begin
      rdata <= mem[rd_addr];
    end
  end

  // MAC pipeline: operand fetch, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
  end

  assign op_i = s1_x ? x_i : rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign op_q = s1_x ? x_q : rdata[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    s1_x   <= (k == '0);
    s1_c   <= coef_k;
    prod_i <= op_i * s1_c;
    prod_q <= op_q * s1_c;
    if (accept) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (s2_v) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up to the sample LSB, then saturate
  assign sum_i = {acc_i[ACC_W-1], acc_i} + HALF_LSB;
  assign sum_q = {acc_q[ACC_W-1], acc_q} + HALF_LSB;
  assign y_i   = saturate(sum_i[ACC_W:COEF_WIDTH-1]);
  assign y_q   = saturate(sum_q[ACC_W:COEF_WIDTH-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.out_i <= y_i;
      result.out_q <= y_q;
    end
  end

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !s1_v && !s2_v)
    else $error("MAC pipeline busy while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vc <= KW'(DEPTH) && n <= KW'(DEPTH))
    else $error("history count beyond depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= AW'(DEPTH - 1))
    else $error("history pointer out of range");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> k <= n)
    else $error("tap index passed taps in use");

  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    finish |=> !finish && state == S_IDLE)
    else $error("result produced twice for one transaction");
`endif

endmodule

@@ sim/tb_complex_fir_lowpass_filter.sv @@
`timescale 1ns / 1ps

module tb_complex_fir_lowpass_filter;
  import cfir_pkg::*;

  localparam int TAPS         = TAPS_DEF;
  localparam int DEPTH        = TAPS - 1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int N_ROWS       = 18;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] si;
    logic signed [SAMPLE_W-1:0] sq;
    logic                       bs;
    logic                       lit;
    logic signed [SAMPLE_W-1:0] wi;
    logic signed [SAMPLE_W-1:0] wq;
  } dir_row_t;

  // Fixed expectations only where they follow from the first tap alone.
  localparam dir_row_t DIRECTED [N_ROWS] = '{
    '{16'sh7fff, 16'sh8000, 1'b0, 1'b1, -16'sd6, 16'sd6},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sd0, 16'sd0},
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, 16'sd6, -16'sd6},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'shffff, 16'sh0001, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh5555, 16'shaaaa, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'shaaaa, 16'sh5555, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh0001, 16'shffff, 1'b1, 1'b1, 16'sd0, 16'sd0},
    '{16'sh4000, 16'shc000, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh1234, 16'shedcb, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sd0, 16'sd0},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0}
  };

  logic      clk;
  logic      rst;
  logic      sample_valid;
  logic      sample_ready;
  in_item_t  sample;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  // Filter history as the block should hold it: [0] in-phase, [1] quadrature.
  logic signed [SAMPLE_W-1:0] hist [2][DEPTH];
  int        wr_ptr;
  int        hist_len;
  out_item_t expected_results [$];

  int mismatches;
  int items_sent;
  int block_starts;
  int results_checked;
  int saturated_outputs;
  bit no_idle;
  bit hold_done;

  complex_fir_lowpass_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

  function automatic int tap_coef(input int k);
    return (k <= 19) ? HALF_TAPS[k] : HALF_TAPS[COEF_COUNT - 1 - k];
  endfunction

  // One channel: multiply-accumulate over the live history, wrap to the
  // accumulator width, round half up to Q1.15 and clip.
  function automatic logic signed [SAMPLE_W-1:0] tap_sum(input int ch,
                                                         input logic signed [SAMPLE_W-1:0] x);
    longint                  acc;
    logic signed [ACC_W-1:0] acc_wrap;
    longint                  y;
    int                      idx;
    acc = longint'(tap_coef(0)) * longint'(x);
    for (int k = 1; k <= hist_len; k++) begin
      idx = (wr_ptr + DEPTH - k) % DEPTH;
      acc += longint'(tap_coef(k)) * longint'(hist[ch][idx]);
    end
    acc_wrap = acc[ACC_W-1:0];
    y = (longint'(acc_wrap) + 65536) >>> 17;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic out_item_t filter_step(input in_item_t it);
    out_item_t r;
    if (it.block_start) hist_len = 0;
    r.out_i = tap_sum(0, it.sample_i);
    r.out_q = tap_sum(1, it.sample_q);
    hist[0][wr_ptr] = it.sample_i;
    hist[1][wr_ptr] = it.sample_q;
    wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
    if (hist_len < DEPTH) hist_len++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH t=%0t %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one transaction, optionally after an idle gap, and log its outcome.
  task automatic offer_sample(input in_item_t it, input bit lit, input out_item_t lit_want);
    out_item_t pred;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    sample       <= it;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    pred = filter_step(it);
    expected_results.push_back(lit ? lit_want : pred);
    items_sent++;
    if (it.block_start) block_starts++;
  endtask

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    result_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= 400) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, out_i", result.out_i, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.out_i !== want.out_i) report_mismatch("out_i", result.out_i, want.out_i);
        if (result.out_q !== want.out_q) report_mismatch("out_q", result.out_q, want.out_q);
        if (result.out_i == 16'sh7fff || result.out_i == 16'sh8000 ||
            result.out_q == 16'sh7fff || result.out_q == 16'sh8000) saturated_outputs++;
      end
    end
  end

  initial begin : stimulus
    in_item_t                   it;
    out_item_t                  lit_want;
    int                         kind;
    int                         seg_len;
    int                         random_sent;
    bit                         flip;
    bit                         drained;
    logic signed [SAMPLE_W-1:0] extremes [4];

    extremes     = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    wr_ptr       = 0;
    hist_len     = 0;
    random_sent  = 0;
    drained      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++) begin
      it.sample_i      = DIRECTED[r].si;
      it.sample_q      = DIRECTED[r].sq;
      it.block_start   = DIRECTED[r].bs;
      lit_want.out_i   = DIRECTED[r].wi;
      lit_want.out_q   = DIRECTED[r].wq;
      offer_sample(it, DIRECTED[r].lit, lit_want);
    end

    while (random_sent < RANDOM_ITEMS) begin
      no_idle = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      // Pause the source once until the pipeline has fully emptied.
      if (!drained && random_sent >= 900) begin
        sample_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      kind    = $urandom_range(0, 9);
      seg_len = (kind == 5) ? TAPS : $urandom_range(1, 90);
      flip    = $urandom_range(0, 1);
      for (int j = 0; j < seg_len; j++) begin
        it.sample_i    = 16'($urandom);
        it.sample_q    = 16'($urandom);
        it.block_start = (j == 0) && kind != 7 && kind != 9;
        case (kind)
          5: begin
            // Match each sample's sign to its tap so the last output clips.
            it.sample_i = ((tap_coef(j) >= 0) ^ flip) ? 16'sh7fff : 16'sh8000;
            it.sample_q = ~it.sample_i;
          end
          6: begin
            it.sample_i = 16'(int'($urandom_range(0, 8)) - 4);
            it.sample_q = 16'(int'($urandom_range(0, 8)) - 4);
          end
          7: it.block_start = ($urandom_range(0, 3) == 0);
          8: begin
            it.sample_i = extremes[$urandom_range(0, 3)];
            it.sample_q = extremes[$urandom_range(0, 3)];
          end
          default: ;
        endcase
        offer_sample(it, 1'b0, '0);
        random_sent++;
      end
    end

    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Filtered %0d complex samples, %0d of them opening a block; %0d results checked.",
             items_sent, block_starts, results_checked);
    $display("Clipped outputs seen: %0d; mismatches: %0d.", saturated_outputs, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
